@@ hw/rtl/clex_pkg.sv @@
// Package: shared types, constants and helpers of the C subset lexer.
`default_nettype none
package clex_pkg;

	localparam int SYMBOL_ENTRIES = 64;
	localparam int NAME_CHARS     = 32;
	localparam int KEYWORD_COUNT  = 8;

	localparam int SYM_IW  = $clog2(SYMBOL_ENTRIES);
	localparam int CNT_W   = $clog2(SYMBOL_ENTRIES + 1);
	localparam int POS_W   = $clog2(NAME_CHARS);
	localparam int LEN_W   = $clog2(NAME_CHARS + 1);
	localparam int NADDR_W = $clog2(SYMBOL_ENTRIES * NAME_CHARS);

	// Token kinds
	localparam logic [2:0] K_KEYWORD = 3'd0;
	localparam logic [2:0] K_IDENT   = 3'd1;
	localparam logic [2:0] K_CONST   = 3'd2;
	localparam logic [2:0] K_OP      = 3'd3;
	localparam logic [2:0] K_SPECIAL = 3'd4;

	// Operator codes
	localparam logic [3:0] OP_LE     = 4'd0;
	localparam logic [3:0] OP_LT     = 4'd1;
	localparam logic [3:0] OP_GE     = 4'd2;
	localparam logic [3:0] OP_GT     = 4'd3;
	localparam logic [3:0] OP_NE     = 4'd4;
	localparam logic [3:0] OP_NOT    = 4'd5;
	localparam logic [3:0] OP_EQ     = 4'd6;
	localparam logic [3:0] OP_ASSIGN = 4'd7;
	localparam logic [3:0] OP_ADD    = 4'd8;
	localparam logic [3:0] OP_SUB    = 4'd9;
	localparam logic [3:0] OP_MUL    = 4'd10;
	localparam logic [3:0] OP_DIV    = 4'd11;
	localparam logic [3:0] OP_AND    = 4'd12;
	localparam logic [3:0] OP_OR     = 4'd13;

	// Error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_NAME_TRUNC = 2'd1;
	localparam logic [1:0] ERR_TABLE_FULL = 2'd2;
	localparam logic [1:0] ERR_CONST_TRUNC = 2'd3;

	// Keyword text, right-aligned, and lengths
	localparam logic [47:0] KW_STR [KEYWORD_COUNT] = '{
		48'("int"), 48'("float"), 48'("return"), 48'("if"),
		48'("else"), 48'("while"), 48'("for"), 48'("char")
	};
	localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
		3'd3, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4
	};

	typedef enum logic [3:0] {
		M_IDLE, M_LT, M_GT, M_BANG, M_EQ, M_AMP, M_BAR, M_NUM, M_NAME
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_STEP1, ST_STEP2, ST_STEP3, ST_KW, ST_RLEN, ST_CLEN,
		ST_RCHR, ST_CCHR, ST_RCPY, ST_WCPY, ST_NEMIT
	} state_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} src_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [3:0] token_code;
		logic [5:0] symbol_index;
		logic       symbol_is_new;
		logic [5:0] token_length;
		logic [7:0] special_char;
		logic [1:0] error_flag;
		logic       last_of_run;
	} tok_t;

	// Character of keyword k at position pos (pos below the keyword length)
	function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
		logic [2:0] sel;
		sel = KW_LEN[k] - 3'd1 - pos;
		return KW_STR[k][{sel, 3'b000} +: 8];
	endfunction

	function automatic tok_t make_tok(input logic [2:0] kind, input logic [3:0] code,
			input logic [7:0] spec, input logic last);
		tok_t t;
		t = '0;
		t.token_kind   = kind;
		t.token_code   = code;
		t.special_char = spec;
		t.last_of_run  = last;
		return t;
	endfunction

	// Keyword or identifier token with its table fields
	function automatic tok_t make_sym_tok(input logic [2:0] kind, input logic [3:0] code,
			input logic [5:0] idx, input logic is_new, input logic [5:0] len,
			input logic [1:0] err);
		tok_t t;
		t = '0;
		t.token_kind    = kind;
		t.token_code    = code;
		t.symbol_index  = idx;
		t.symbol_is_new = is_new;
		t.token_length  = len;
		t.error_flag    = err;
		return t;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/c_subset_lexer_with_symbol_table.sv @@
// Top level: character-stream lexer for a C subset with an identifier table.
//
// Usage: bytes enter on the char channel (char_valid/char_stall/char_data), one
// per transfer, with end_of_text marking the final byte. Tokens leave on the tok
// channel (tok_valid/tok_stall/tok_data); a byte causes zero, one or two tokens,
// and last_of_run marks the final token of a byte.
// Rate: one byte at a time. A byte passes the idle state and up to three decode
// steps before it is ready again; a byte that completes an operator pair ends
// after the first step, a single operator or special character after the second.
// A byte that ends an identifier adds a keyword check and, on a miss, a table
// search in the symbol memories: each entry's length is read and compared, the
// characters of an entry of equal length are compared, and a new name is
// appended character by character while the table has room; then the token is emitted.
// Output: a token is registered and appears in the cycle after its step.
// Reset clears the mode, the token length and the symbol count; the memories
// need no clearing pass since only written entries are read.
// When the receiver stalls, the output register holds its token and the
// sequencer waits at its next decode or emit step.
`default_nettype none
module c_subset_lexer_with_symbol_table
	import clex_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  char_valid,
	output logic char_stall,
	input  src_t char_data,
	output logic tok_valid,
	input  wire  tok_stall,
	output tok_t tok_data
);

	state_t state_q, state_d, ret_q;
	mode_t  mode_q, pend_mode;
	logic [7:0] c_q;
	logic eot_q;
	logic [LEN_W-1:0] len_q;
	logic over_q;
	logic [CNT_W-1:0] count_q;
	logic [SYM_IW-1:0] i_q;
	logic [POS_W-1:0] j_q;
	logic [KEYWORD_COUNT-1:0] kw_q;
	tok_t nres_q, res, out_q;
	logic out_valid_q, last_name_q;

	// Memories
	logic [7:0] text_mem [NAME_CHARS];
	logic [7:0] names_mem [SYMBOL_ENTRIES * NAME_CHARS];
	logic [LEN_W-1:0] lens_mem [SYMBOL_ENTRIES];
	logic [7:0] text_rd, name_rd;
	logic [LEN_W-1:0] len_rd;
	logic text_we, names_we, lens_we;
	logic [POS_W-1:0] text_wa;
	logic [NADDR_W-1:0] name_ra, name_wa;

	// Character classes of the held byte
	logic c_dig, c_nstart, c_namec, c_space, c_pend, c_single, c_modeful, c_emits, more1;
	logic [3:0] single_code;
	logic [7:0] pair_ch;
	logic [3:0] pair_code;
	tok_t flush_res;
	logic emit, adv, out_free, append, kw_hit, last_entry, full, j_end;
	logic [3:0] kw_code;

	assign out_free  = !out_valid_q || !tok_stall;
	assign adv       = out_free;
	assign tok_valid = out_valid_q;
	assign tok_data  = out_q;
	assign char_stall = (state_q != ST_IDLE);

	assign c_dig    = (c_q >= "0") && (c_q <= "9");
	assign c_nstart = ((c_q >= "a") && (c_q <= "z")) || ((c_q >= "A") && (c_q <= "Z"))
		|| (c_q == "_");
	assign c_namec  = c_nstart || c_dig;
	assign c_space  = (c_q == " ") || ((c_q >= 8'd9) && (c_q <= 8'd13));

	// Decode operator starts and single operators
	always_comb begin
		c_pend = 1'b1;
		pend_mode = M_IDLE;
		c_single = 1'b1;
		single_code = OP_ADD;
		case (c_q)
			"<": pend_mode = M_LT;
			">": pend_mode = M_GT;
			"!": pend_mode = M_BANG;
			"=": pend_mode = M_EQ;
			"&": pend_mode = M_AMP;
			"|": pend_mode = M_BAR;
			default: c_pend = 1'b0;
		endcase
		case (c_q)
			"+": single_code = OP_ADD;
			"-": single_code = OP_SUB;
			"*": single_code = OP_MUL;
			"/": single_code = OP_DIV;
			default: c_single = 1'b0;
		endcase
	end

	assign c_modeful = c_pend || c_dig || c_nstart;
	assign c_emits   = !c_space && !c_modeful;
	assign more1     = c_emits || (eot_q && c_modeful);

	// Pair completion and lone flush of pending operator modes
	always_comb begin
		pair_ch = "=";
		pair_code = OP_LE;
		flush_res = make_tok(K_OP, OP_LT, 8'd0, 1'b0);
		case (mode_q)
			M_LT: begin
				pair_code = OP_LE;
				flush_res = make_tok(K_OP, OP_LT, 8'd0, 1'b0);
			end
			M_GT: begin
				pair_code = OP_GE;
				flush_res = make_tok(K_OP, OP_GT, 8'd0, 1'b0);
			end
			M_BANG: begin
				pair_code = OP_NE;
				flush_res = make_tok(K_OP, OP_NOT, 8'd0, 1'b0);
			end
			M_EQ: begin
				pair_code = OP_EQ;
				flush_res = make_tok(K_OP, OP_ASSIGN, 8'd0, 1'b0);
			end
			M_AMP: begin
				pair_ch = "&";
				pair_code = OP_AND;
				flush_res = make_tok(K_SPECIAL, 4'd0, "&", 1'b0);
			end
			M_BAR: begin
				pair_ch = "|";
				pair_code = OP_OR;
				flush_res = make_tok(K_SPECIAL, 4'd0, "|", 1'b0);
			end
			default: ;
		endcase
	end

	// Keyword hit from the running prefix flags
	always_comb begin
		kw_hit = 1'b0;
		kw_code = 4'd0;
		for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
			if (kw_q[k] && (len_q == LEN_W'(KW_LEN[k]))) begin
				kw_hit = 1'b1;
				kw_code = 4'(k);
			end
		end
	end

	assign last_entry = (CNT_W'(i_q) + CNT_W'(1)) == count_q;
	assign full       = count_q == CNT_W'(SYMBOL_ENTRIES);
	assign j_end      = (LEN_W'(j_q) + LEN_W'(1)) == len_q;
	assign append     = ((mode_q == M_NUM) && c_dig) || ((mode_q == M_NAME) && c_namec);

	// Token produced in the current step
	always_comb begin
		emit = 1'b0;
		res = '0;
		case (state_q)
			ST_STEP1: begin
				if (mode_q == M_LT || mode_q == M_GT || mode_q == M_BANG || mode_q == M_EQ
						|| mode_q == M_AMP || mode_q == M_BAR) begin
					emit = 1'b1;
					if (c_q == pair_ch) begin
						res = make_tok(K_OP, pair_code, 8'd0, 1'b1);
					end else begin
						res = flush_res;
						res.last_of_run = !more1;
					end
				end else if (mode_q == M_NUM && !c_dig) begin
					emit = 1'b1;
					res = make_tok(K_CONST, 4'd0, 8'd0, !more1);
					res.token_length = 6'(len_q);
					res.error_flag = over_q ? ERR_CONST_TRUNC : ERR_NONE;
				end
			end
			ST_STEP2: begin
				if (c_single) begin
					emit = 1'b1;
					res = make_tok(K_OP, single_code, 8'd0, 1'b1);
				end else if (c_emits) begin
					emit = 1'b1;
					res = make_tok(K_SPECIAL, 4'd0, c_q, 1'b1);
				end
			end
			ST_STEP3: begin
				if (eot_q) begin
					if (mode_q == M_NUM) begin
						emit = 1'b1;
						res = make_tok(K_CONST, 4'd0, 8'd0, 1'b1);
						res.token_length = 6'(len_q);
						res.error_flag = over_q ? ERR_CONST_TRUNC : ERR_NONE;
					end else if (mode_q != M_IDLE && mode_q != M_NAME) begin
						emit = 1'b1;
						res = flush_res;
						res.last_of_run = 1'b1;
					end
				end
			end
			ST_NEMIT: begin
				emit = 1'b1;
				res = nres_q;
				res.last_of_run = last_name_q;
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (char_valid) state_d = ST_STEP1;
			ST_STEP1: begin
				if (adv) begin
					case (mode_q)
						M_IDLE: state_d = ST_STEP2;
						M_NUM:  state_d = c_dig ? ST_STEP3 : ST_STEP2;
						M_NAME: state_d = c_namec ? ST_STEP3 : ST_KW;
						default: state_d = (c_q == pair_ch) ? ST_IDLE : ST_STEP2;
					endcase
				end
			end
			ST_STEP2: if (adv) state_d = c_emits ? ST_IDLE : ST_STEP3;
			ST_STEP3: if (adv) state_d = (eot_q && mode_q == M_NAME) ? ST_KW : ST_IDLE;
			ST_KW: begin
				if (kw_hit) state_d = ST_NEMIT;
				else if (count_q == '0) state_d = ST_RCPY;
				else state_d = ST_RLEN;
			end
			ST_RLEN: state_d = ST_CLEN;
			ST_CLEN: begin
				if (len_rd == len_q) state_d = ST_RCHR;
				else if (!last_entry) state_d = ST_RLEN;
				else state_d = full ? ST_NEMIT : ST_RCPY;
			end
			ST_RCHR: state_d = ST_CCHR;
			ST_CCHR: begin
				if (name_rd == text_rd) state_d = j_end ? ST_NEMIT : ST_RCHR;
				else if (!last_entry) state_d = ST_RLEN;
				else state_d = full ? ST_NEMIT : ST_RCPY;
			end
			ST_RCPY: state_d = ST_WCPY;
			ST_WCPY: state_d = j_end ? ST_NEMIT : ST_RCPY;
			ST_NEMIT: if (adv) state_d = ret_q;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory write controls
	always_comb begin
		text_we = 1'b0;
		text_wa = len_q[POS_W-1:0];
		if (state_q == ST_STEP1 && adv && append && (len_q < LEN_W'(NAME_CHARS))) begin
			text_we = 1'b1;
		end else if (state_q == ST_STEP2 && adv && !c_space && !c_pend
				&& (c_dig || c_nstart)) begin
			text_we = 1'b1;
			text_wa = '0;
		end
	end
	assign names_we = (state_q == ST_WCPY);
	assign lens_we  = (state_q == ST_WCPY) && j_end;
	assign name_ra  = NADDR_W'(i_q) * NADDR_W'(NAME_CHARS) + NADDR_W'(j_q);
	assign name_wa  = NADDR_W'(count_q[SYM_IW-1:0]) * NADDR_W'(NAME_CHARS) + NADDR_W'(j_q);

	always_ff @(posedge clk) begin
		if (text_we) text_mem[text_wa] <= c_q;
		text_rd <= text_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (names_we) names_mem[name_wa] <= text_rd;
		name_rd <= names_mem[name_ra];
	end

	always_ff @(posedge clk) begin
		if (lens_we) lens_mem[count_q[SYM_IW-1:0]] <= len_q;
		len_rd <= lens_mem[i_q];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && adv) begin
			out_valid_q <= 1'b1;
		end else if (!tok_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && adv) out_q <= res;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= M_IDLE;
			len_q   <= '0;
			over_q  <= 1'b0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_STEP1: begin
					if (adv) begin
						if (append) begin
							if (len_q < LEN_W'(NAME_CHARS)) len_q <= len_q + LEN_W'(1);
							else over_q <= 1'b1;
						end else if (mode_q != M_NAME) begin
							mode_q <= M_IDLE;
							len_q  <= '0;
							over_q <= 1'b0;
						end
					end
				end
				ST_STEP2: begin
					if (adv && !c_space) begin
						if (c_pend) begin
							mode_q <= pend_mode;
						end else if (c_dig || c_nstart) begin
							mode_q <= c_dig ? M_NUM : M_NAME;
							len_q  <= LEN_W'(1);
							over_q <= 1'b0;
						end
					end
				end
				ST_STEP3: begin
					if (adv && eot_q && mode_q != M_NAME) begin
						mode_q <= M_IDLE;
						len_q  <= '0;
						over_q <= 1'b0;
					end
				end
				ST_WCPY: if (j_end) count_q <= count_q + CNT_W'(1);
				ST_NEMIT: begin
					if (adv) begin
						mode_q <= M_IDLE;
						len_q  <= '0;
						over_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the step and the table search
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (char_valid) begin
					c_q   <= char_data.char_in;
					eot_q <= char_data.end_of_text;
				end
			end
			ST_STEP1: begin
				if (adv) begin
					if (append && (len_q < LEN_W'(NAME_CHARS))) begin
						for (int k = 0; k < KEYWORD_COUNT; k++) begin
							kw_q[k] <= kw_q[k] && (len_q < LEN_W'(KW_LEN[k]))
								&& (kw_char(k, len_q[2:0]) == c_q);
						end
					end
					if (mode_q == M_NAME && !c_namec) begin
						ret_q <= ST_STEP2;
						last_name_q <= !more1;
					end
				end
			end
			ST_STEP2: begin
				for (int k = 0; k < KEYWORD_COUNT; k++) begin
					kw_q[k] <= kw_char(k, 3'd0) == c_q;
				end
			end
			ST_STEP3: begin
				ret_q <= ST_IDLE;
				last_name_q <= 1'b1;
			end
			ST_KW: begin
				i_q <= '0;
				j_q <= '0;
				nres_q <= make_sym_tok(K_KEYWORD, kw_code, 6'd0, 1'b0, 6'(len_q), ERR_NONE);
			end
			ST_CLEN, ST_CCHR: begin
				if (state_q == ST_CLEN ? (len_rd == len_q) : (name_rd == text_rd)) begin
					if (state_q == ST_CLEN) begin
						j_q <= '0;
					end else if (j_end) begin
						nres_q <= make_sym_tok(K_IDENT, 4'd0, 6'(i_q), 1'b0, 6'(len_q),
							over_q ? ERR_NAME_TRUNC : ERR_NONE);
					end else begin
						j_q <= j_q + POS_W'(1);
					end
				end else if (!last_entry) begin
					i_q <= i_q + SYM_IW'(1);
				end else begin
					j_q <= '0;
					nres_q <= make_sym_tok(K_IDENT, 4'd0, 6'd0, 1'b0, 6'(len_q),
						ERR_TABLE_FULL);
				end
			end
			ST_WCPY: begin
				if (j_end) begin
					nres_q <= make_sym_tok(K_IDENT, 4'd0, 6'(count_q[SYM_IW-1:0]), 1'b1,
						6'(len_q), over_q ? ERR_NAME_TRUNC : ERR_NONE);
				end else begin
					j_q <= j_q + POS_W'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SYMBOL_ENTRIES))
		else $error("symbol count above table size");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("symbol count moved by other than one");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(NAME_CHARS))
		else $error("token length above limit");
	a_search_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RLEN || state_q == ST_CLEN || state_q == ST_RCHR
			|| state_q == ST_CCHR || state_q == ST_RCPY || state_q == ST_WCPY)
		|-> (mode_q == M_NAME))
		else $error("table search outside a name token");
`endif

endmodule
`default_nettype wire
